// ===== hdl/mbrot_pkg.sv =====
// Shared types and constants of the Mandelbrot escape-time shader.
// Used by mbrot_mul and by the top level mandelbrot_escape_time_shader.
// No dependencies.
`default_nettype none

package mbrot_pkg;

    // Stream word widths.
    localparam int IN_DATA_W  = 8;
    localparam int GRAY_W     = 8;
    localparam int ITER_W     = 16;
    localparam int PIX_W      = 12;
    localparam int OUT_DATA_W = GRAY_W + ITER_W + 2 * PIX_W;

    // Configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int ORIGIN_W   = 32;
    localparam int STEP_W     = 31;
    localparam int FSIZE_W    = 13;
    localparam int ESC_W      = 31;

    // Gray division: one quotient bit per cycle.
    localparam int DIV_W      = ITER_W + GRAY_W;
    localparam int BITCNT_W   = $clog2(GRAY_W);

    // Register reset values.
    localparam logic signed [ORIGIN_W-1:0] ORIGIN_X_RST = 32'hE000_0000;
    localparam logic signed [ORIGIN_W-1:0] ORIGIN_Y_RST = 32'h1800_0000;
    localparam logic [STEP_W-1:0]          STEP_RST     = 31'd1258291;
    localparam logic [FSIZE_W-1:0]         WIDTH_RST    = 13'd640;
    localparam logic [FSIZE_W-1:0]         HEIGHT_RST   = 13'd480;
    localparam logic [ITER_W-1:0]          MAX_ITER_RST = 16'd256;
    localparam logic [ESC_W-1:0]           ESC_RST      = 31'h4000_0000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ORIGIN_X     = 3'd0,
        REG_ORIGIN_Y     = 3'd1,
        REG_STEP         = 3'd2,
        REG_FRAME_WIDTH  = 3'd3,
        REG_FRAME_HEIGHT = 3'd4,
        REG_MAX_ITER     = 3'd5,
        REG_ESCAPE_SQ    = 3'd6
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CX,
        ST_CY,
        ST_SQX,
        ST_SQY,
        ST_TEST,
        ST_XY,
        ST_UPD,
        ST_DIV,
        ST_DONE
    } state_t;

    // Command to the shared multiplier.
    typedef struct packed {
        logic start;
        logic neg;
    } mul_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/mbrot_mul.sv =====
// Iterative multiplier shared by all products of the shader.
// Forms a full product from four half-width partial products, then floors and saturates.
// Depends on mbrot_pkg.
`default_nettype none

module mbrot_mul
    import mbrot_pkg::*;
#(
    parameter int OPW       = 36,
    parameter int FRAC_BITS = 28,
    parameter int ZW        = 36
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  mul_ctl_t              ctl,
    input  logic [OPW-1:0]        a,
    input  logic [OPW-1:0]        b,
    output logic                  done,
    output logic [2*OPW-1:0]      prod,
    output logic signed [ZW-1:0]  qres
);

    localparam int HW = OPW / 2;
    localparam int PW = 2 * OPW;
    localparam int QW = PW - FRAC_BITS;
    localparam logic [QW-1:0] ZMAX_Q = {{(QW-ZW+1){1'b0}}, {(ZW-1){1'b1}}};
    localparam logic [ZW-1:0] ZMAX_Z = {1'b0, {(ZW-1){1'b1}}};
    localparam logic [ZW-1:0] ZMIN_Z = {1'b1, {(ZW-1){1'b0}}};

    logic [OPW-1:0] a_reg, b_reg;
    logic           neg_reg;
    logic [PW-1:0]  acc_reg, acc_next;
    logic           busy_reg, busy_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           done_reg, done_next;

    logic [HW-1:0]  a_part, b_part;
    logic [OPW-1:0] pp;
    logic [PW-1:0]  pp_sh;
    logic [QW-1:0]  q;
    logic           rem_nz;
    logic           neg_ovf;

    always_comb
    begin
        a_part = cnt_reg[0] ? a_reg[OPW-1:HW] : a_reg[HW-1:0];
        b_part = cnt_reg[1] ? b_reg[OPW-1:HW] : b_reg[HW-1:0];
        pp     = a_part * b_part;
        case (cnt_reg)
            2'd0:    pp_sh = PW'(pp);
            2'd1:    pp_sh = PW'(pp) << HW;
            2'd2:    pp_sh = PW'(pp) << HW;
            2'd3:    pp_sh = PW'(pp) << (2 * HW);
            default: pp_sh = '0;
        endcase

        acc_next  = acc_reg;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = busy_reg && (cnt_reg == 2'd3);
        if (ctl.start)
        begin
            acc_next  = '0;
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + pp_sh;
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == 2'd3)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (ctl.start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            neg_reg <= ctl.neg;
        end
    end

    // Floor of the scaled product. For a negative result, -(q + r) is ~q + 1 - r.
    always_comb
    begin
        q       = acc_reg[PW-1:FRAC_BITS];
        rem_nz  = |acc_reg[FRAC_BITS-1:0];
        neg_ovf = rem_nz ? (q >= ZMAX_Q) : (q > ZMAX_Q);
        if (!neg_reg)
        begin
            qres = (q > ZMAX_Q) ? $signed(ZMAX_Z) : $signed(q[ZW-1:0]);
        end
        else
        begin
            qres = neg_ovf ? $signed(ZMIN_Z) : $signed(~q[ZW-1:0] + ZW'(!rem_nz));
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

`default_nettype wire

// ===== hdl/mandelbrot_escape_time_shader.sv =====
// Top level of the Mandelbrot escape-time shader: raster scan, iteration sequencer and gray divider.
// Depends on mbrot_pkg and mbrot_mul.
//
// Each input word requests the next pixel of a frame scanned in raster order; bit 0 of the
// word restarts the scan at the top-left pixel first. The pixel at column col and row row
// stands for c = (origin_x + col*step, origin_y - row*step) in signed Q8.FRAC_BITS, and the
// block iterates z = z*z + c from zero, stopping when |z|^2 exceeds escape_radius_sq or the
// count reaches max_iter. Every intermediate value saturates to signed Q8.FRAC_BITS. The
// result word carries the gray level floor(255*count/max_iter), the count and the pixel
// coordinates, with tlast marking the last pixel of the frame. All products go through one
// shared multiplier that builds each product from four half-width partial products. Forming c
// takes two products, each iteration three products (x*x, y*y and x*y) plus a test and an
// update state, and the final escape test two products and a test, followed by the bit-serial
// gray division. The block takes a new word only between pixels; a finished word waits in the
// output register, so the next pixel can already be computed while it is held. Configuration
// is to be written through cfg_we/cfg_addr/cfg_wdata only while the block is idle; the block
// itself does not enforce this. A frame size of zero acts as one and a size above 2^DIM_BITS
// acts as 2^DIM_BITS.
`default_nettype none

module mandelbrot_escape_time_shader
    import mbrot_pkg::*;
#(
    parameter int FRAC_BITS = 28,
    parameter int DIM_BITS  = 12
)(
    input  logic                  clk,
    input  logic                  rst_n,
    // Request stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [0] restart, [7:1] zero
    // Pixel stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] gray, [23:8] iterations,
                                             // [35:24] pixel_col, [47:36] pixel_row
    output logic                  m_tlast,   // last pixel of the frame
    // Configuration write port.
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Working value format and derived widths.
    localparam int ZW   = FRAC_BITS + 8;
    localparam int OPW0 = (ZW > 32) ? ZW : 32;
    localparam int OPW  = OPW0 + (OPW0 % 2);
    localparam int PW   = 2 * OPW;
    localparam int PC_W = DIM_BITS + STEP_W;
    localparam int SW0  = (PC_W > ZW) ? PC_W : ZW;
    localparam int SW   = ((SW0 > ORIGIN_W) ? SW0 : ORIGIN_W) + 2;
    localparam int CMPW = (ZW > ESC_W) ? ZW : ESC_W;
    localparam int SZW0 = (DIM_BITS + 1 > FSIZE_W) ? DIM_BITS + 1 : FSIZE_W;
    localparam int SZW  = SZW0 + 1;

    localparam logic signed [SW-1:0] ZMAX_S = {{(SW-ZW+1){1'b0}}, {(ZW-1){1'b1}}};
    localparam logic signed [SW-1:0] ZMIN_S = {{(SW-ZW+1){1'b1}}, {(ZW-1){1'b0}}};
    localparam logic [ZW-1:0]        ZMAX_Z = {1'b0, {(ZW-1){1'b1}}};
    localparam logic [ZW-1:0]        ZMIN_Z = {1'b1, {(ZW-1){1'b0}}};
    localparam logic [SZW-1:0]       DIM_LIMIT =
        {{(SZW-DIM_BITS-1){1'b0}}, 1'b1, {DIM_BITS{1'b0}}};

    function automatic logic signed [ZW-1:0] sat_z(input logic signed [SW-1:0] v);
        logic signed [ZW-1:0] r;
        if (v > ZMAX_S)
        begin
            r = $signed(ZMAX_Z);
        end
        else if (v < ZMIN_S)
        begin
            r = $signed(ZMIN_Z);
        end
        else
        begin
            r = $signed(v[ZW-1:0]);
        end
        return r;
    endfunction

    // Saturated double of a working value.
    function automatic logic signed [ZW-1:0] sat_dbl(input logic signed [ZW-1:0] v);
        logic signed [ZW-1:0] r;
        if (v[ZW-1] != v[ZW-2])
        begin
            r = v[ZW-1] ? $signed(ZMIN_Z) : $signed(ZMAX_Z);
        end
        else
        begin
            r = $signed({v[ZW-2:0], 1'b0});
        end
        return r;
    endfunction

    function automatic logic [OPW-1:0] mag(input logic signed [ZW-1:0] v);
        logic [ZW-1:0] m;
        m = v[ZW-1] ? (~v + 1'b1) : v;
        return OPW'(m);
    endfunction

    function automatic logic [SZW-1:0] eff_size(input logic [FSIZE_W-1:0] v);
        logic [SZW-1:0] r;
        r = SZW'(v);
        if (v == '0)
        begin
            r = SZW'(1);
        end
        else if (r > DIM_LIMIT)
        begin
            r = DIM_LIMIT;
        end
        return r;
    endfunction

    // Configuration registers.
    logic signed [ORIGIN_W-1:0] origin_x_reg, origin_y_reg;
    logic [STEP_W-1:0]          step_reg;
    logic [FSIZE_W-1:0]         width_reg, height_reg;
    logic [ITER_W-1:0]          max_iter_reg;
    logic [ESC_W-1:0]           esc_reg;

    // Control state.
    state_t                state_reg, state_next;
    logic                  issued_reg, issued_next;
    logic [DIM_BITS-1:0]   scan_col_reg, scan_col_next;
    logic [DIM_BITS-1:0]   scan_row_reg, scan_row_next;
    logic                  out_valid_reg, out_valid_next;

    // Pixel payload.
    logic [DIM_BITS-1:0]   col_reg, col_next;
    logic [DIM_BITS-1:0]   row_reg, row_next;
    logic                  fend_reg, fend_next;
    logic signed [ZW-1:0]  cx_reg, cx_next;
    logic signed [ZW-1:0]  cy_reg, cy_next;
    logic signed [ZW-1:0]  x_reg, x_next;
    logic signed [ZW-1:0]  y_reg, y_next;
    logic signed [ZW-1:0]  xx_reg, xx_next;
    logic signed [ZW-1:0]  yy_reg, yy_next;
    logic signed [ZW-1:0]  xy_reg, xy_next;
    logic signed [ZW-1:0]  t1_reg, t1_next;
    logic [ITER_W-1:0]     count_reg, count_next;
    logic [DIV_W-1:0]      rem_reg, rem_next;
    logic [DIV_W-1:0]      dsr_reg, dsr_next;
    logic [GRAY_W-1:0]     quot_reg, quot_next;
    logic [BITCNT_W-1:0]   bitcnt_reg, bitcnt_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                  out_last_reg, out_last_next;

    // Shared multiplier.
    mul_ctl_t              mul_ctl;
    logic [OPW-1:0]        mul_a, mul_b;
    logic                  mul_done;
    logic [PW-1:0]         mul_prod;
    logic signed [ZW-1:0]  mul_q;

    // Scan and datapath helpers.
    logic                  restart;
    logic [DIM_BITS-1:0]   col_now, row_now;
    logic [SZW-1:0]        col_inc, row_inc, w_eff, h_eff;
    logic                  row_end, frame_end;
    logic signed [ZW-1:0]  r2;
    logic                  esc_hit;
    logic [GRAY_W-1:0]     gray;
    logic                  qbit;
    logic [DIM_BITS+PIX_W-1:0] col_wide, row_wide;

    mbrot_mul #(
        .OPW       (OPW),
        .FRAC_BITS (FRAC_BITS),
        .ZW        (ZW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mul_ctl),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod),
        .qres  (mul_q)
    );

    // Raster position of the requested pixel and the scan position after it.
    always_comb
    begin
        restart   = s_tdata[0];
        col_now   = restart ? '0 : scan_col_reg;
        row_now   = restart ? '0 : scan_row_reg;
        w_eff     = eff_size(width_reg);
        h_eff     = eff_size(height_reg);
        col_inc   = SZW'(col_now) + SZW'(1);
        row_inc   = SZW'(row_now) + SZW'(1);
        row_end   = col_inc >= w_eff;
        frame_end = row_end && (row_inc >= h_eff);
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_ctl.neg = 1'b0;
        case (state_reg)
            ST_CX:
            begin
                mul_a = OPW'(col_reg);
                mul_b = OPW'(step_reg);
            end
            ST_CY:
            begin
                mul_a = OPW'(row_reg);
                mul_b = OPW'(step_reg);
            end
            ST_SQX:
            begin
                mul_a = mag(x_reg);
                mul_b = mag(x_reg);
            end
            ST_SQY:
            begin
                mul_a = mag(y_reg);
                mul_b = mag(y_reg);
            end
            ST_XY:
            begin
                mul_a       = mag(x_reg);
                mul_b       = mag(y_reg);
                mul_ctl.neg = x_reg[ZW-1] ^ y_reg[ZW-1];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        issued_next    = issued_reg;
        scan_col_next  = scan_col_reg;
        scan_row_next  = scan_row_reg;
        out_valid_next = out_valid_reg && !m_tready;
        col_next       = col_reg;
        row_next       = row_reg;
        fend_next      = fend_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        xx_next        = xx_reg;
        yy_next        = yy_reg;
        xy_next        = xy_reg;
        t1_next        = t1_reg;
        count_next     = count_reg;
        rem_next       = rem_reg;
        dsr_next       = dsr_reg;
        quot_next      = quot_reg;
        bitcnt_next    = bitcnt_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        mul_ctl.start  = 1'b0;
        s_tready       = 1'b0;

        r2      = sat_z(SW'(xx_reg) + SW'(yy_reg));
        esc_hit = CMPW'($unsigned(r2)) > CMPW'(esc_reg);
        qbit    = rem_reg >= dsr_reg;
        gray    = (max_iter_reg == '0) ? '0 : quot_reg;

        col_wide = {{PIX_W{1'b0}}, col_reg};
        row_wide = {{PIX_W{1'b0}}, row_reg};

        // Multiplier states issue the product once and advance when it is done.
        if ((state_reg == ST_CX || state_reg == ST_CY || state_reg == ST_SQX ||
             state_reg == ST_SQY || state_reg == ST_XY) && !issued_reg)
        begin
            mul_ctl.start = 1'b1;
            issued_next   = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    col_next      = col_now;
                    row_next      = row_now;
                    fend_next     = frame_end;
                    scan_col_next = row_end ? '0 : col_inc[DIM_BITS-1:0];
                    scan_row_next = frame_end ? '0 :
                                    (row_end ? row_inc[DIM_BITS-1:0] : row_now);
                    state_next    = ST_CX;
                end
            end
            ST_CX:
            begin
                if (mul_done)
                begin
                    issued_next = 1'b0;
                    cx_next     = sat_z(SW'(origin_x_reg) + $signed(SW'(mul_prod[PC_W-1:0])));
                    state_next  = ST_CY;
                end
            end
            ST_CY:
            begin
                if (mul_done)
                begin
                    issued_next = 1'b0;
                    cy_next     = sat_z(SW'(origin_y_reg) - $signed(SW'(mul_prod[PC_W-1:0])));
                    x_next      = '0;
                    y_next      = '0;
                    count_next  = '0;
                    state_next  = ST_SQX;
                end
            end
            ST_SQX:
            begin
                if (mul_done)
                begin
                    issued_next = 1'b0;
                    xx_next     = mul_q;
                    state_next  = ST_SQY;
                end
            end
            ST_SQY:
            begin
                if (mul_done)
                begin
                    issued_next = 1'b0;
                    yy_next     = mul_q;
                    state_next  = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if (esc_hit || (count_reg == max_iter_reg))
                begin
                    // Start the gray division: 255*count over max_iter, MSB first.
                    rem_next    = {count_reg, {GRAY_W{1'b0}}} - DIV_W'(count_reg);
                    dsr_next    = DIV_W'({max_iter_reg, {(GRAY_W-1){1'b0}}});
                    quot_next   = '0;
                    bitcnt_next = '0;
                    state_next  = ST_DIV;
                end
                else
                begin
                    t1_next    = sat_z(SW'(xx_reg) - SW'(yy_reg));
                    state_next = ST_XY;
                end
            end
            ST_XY:
            begin
                if (mul_done)
                begin
                    issued_next = 1'b0;
                    xy_next     = mul_q;
                    state_next  = ST_UPD;
                end
            end
            ST_UPD:
            begin
                x_next     = sat_z(SW'(t1_reg) + SW'(cx_reg));
                y_next     = sat_z(SW'(sat_dbl(xy_reg)) + SW'(cy_reg));
                count_next = count_reg + 1'b1;
                state_next = ST_SQX;
            end
            ST_DIV:
            begin
                if (qbit)
                begin
                    rem_next = rem_reg - dsr_reg;
                end
                quot_next   = {quot_reg[GRAY_W-2:0], qbit};
                dsr_next    = dsr_reg >> 1;
                bitcnt_next = bitcnt_reg + 1'b1;
                if (bitcnt_reg == BITCNT_W'(GRAY_W - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hand the pixel over once the output register is free.
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {row_wide[PIX_W-1:0], col_wide[PIX_W-1:0],
                                      count_reg, gray};
                    out_last_next  = fend_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            scan_col_reg  <= '0;
            scan_row_reg  <= '0;
            out_valid_reg <= 1'b0;
            origin_x_reg  <= ORIGIN_X_RST;
            origin_y_reg  <= ORIGIN_Y_RST;
            step_reg      <= STEP_RST;
            width_reg     <= WIDTH_RST;
            height_reg    <= HEIGHT_RST;
            max_iter_reg  <= MAX_ITER_RST;
            esc_reg       <= ESC_RST;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            scan_col_reg  <= scan_col_next;
            scan_row_reg  <= scan_row_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_addr))
                    REG_ORIGIN_X:     origin_x_reg <= $signed(cfg_wdata[ORIGIN_W-1:0]);
                    REG_ORIGIN_Y:     origin_y_reg <= $signed(cfg_wdata[ORIGIN_W-1:0]);
                    REG_STEP:         step_reg     <= cfg_wdata[STEP_W-1:0];
                    REG_FRAME_WIDTH:  width_reg    <= cfg_wdata[FSIZE_W-1:0];
                    REG_FRAME_HEIGHT: height_reg   <= cfg_wdata[FSIZE_W-1:0];
                    REG_MAX_ITER:     max_iter_reg <= cfg_wdata[ITER_W-1:0];
                    REG_ESCAPE_SQ:    esc_reg      <= cfg_wdata[ESC_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg      <= col_next;
        row_reg      <= row_next;
        fend_reg     <= fend_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        xx_reg       <= xx_next;
        yy_reg       <= yy_next;
        xy_reg       <= xy_next;
        t1_reg       <= t1_next;
        count_reg    <= count_next;
        rem_reg      <= rem_next;
        dsr_reg      <= dsr_next;
        quot_reg     <= quot_next;
        bitcnt_reg   <= bitcnt_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire
